// ===== sv/circular_fifo_with_remove_at_slot_defines.svh =====
// ----------------------------------------------------------------------------
// circular fifo with remove-at-slot: assertion macros
// concurrent checks, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_WITH_REMOVE_AT_SLOT_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_REMOVE_AT_SLOT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// plain property, checked outside reset
`define CFQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// overlapping implication, checked outside reset
`define CFQ_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`else
`define CFQ_ASSERT(lbl, clk, rstn, prop, msg)
`define CFQ_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// ===== sv/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// shared types, codes and sizes of the circular fifo with remove-at-slot
// ----------------------------------------------------------------------------
package cfq_pkg;

  // sizes
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  // operation codes
  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_REM = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_NO_SLOT = 2'd3
  } status_e;

  // register map
  typedef enum logic [PADDR_W-1:0] {
    REG_CAPACITY = 2'd0
  } reg_addr_e;

  // input transaction
  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] value;
    logic [SLOT_W-1:0] slot;
  } cfq_in_t;

  // output transaction
  typedef struct packed {
    logic [DATA_W-1:0]  removed_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
  } cfq_out_t;

  // strobes broadcast to the cell row
  typedef struct packed {
    logic wr;  // write at the tail cell
    logic rd;  // drive the addressed cell onto the read bus
    logic sh;  // close the gap behind a removed entry
  } cell_op_t;

endpackage

// ===== sv/cfq_cell.sv =====
// ----------------------------------------------------------------------------
// cfq_cell
// one storage slot of the ring: loads from the tail write or from its ring
// neighbour when an entry in front of it is removed
// ----------------------------------------------------------------------------
module cfq_cell #(
  parameter int unsigned  DEPTH = cfq_pkg::DEPTH_DEF,
  parameter int unsigned  IDX   = 0,
  localparam int unsigned IW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  cfq_pkg::cell_op_t          op_i,
  input  logic [CW-1:0]              cap_i,
  input  logic [IW-1:0]              head_i,
  input  logic [IW-1:0]              tail_i,
  input  logic [IW-1:0]              rd_idx_i,
  input  logic [CW-1:0]              offset_i,
  input  logic [CW-1:0]              count_i,
  input  logic [cfq_pkg::DATA_W-1:0] wdata_i,
  input  logic [cfq_pkg::DATA_W-1:0] next_data_i,
  input  logic [cfq_pkg::DATA_W-1:0] wrap_data_i,
  output logic [cfq_pkg::DATA_W-1:0] data_o,
  output logic [cfq_pkg::DATA_W-1:0] rd_data_o
);
  import cfq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  logic [DATA_W-1:0] data_q, data_d;
  logic [CW-1:0]     ring_pos;
  logic [CW:0]       ring_pos_inc;
  logic              active;
  logic              last;
  logic              shift;
  logic [DATA_W-1:0] nb_data;

  // position of this slot counted from the head, modulo the ring size
  always_comb begin
    if (MY_POS >= CW'(head_i)) begin
      ring_pos = MY_POS - CW'(head_i);
    end else begin
      ring_pos = MY_POS + cap_i - CW'(head_i);
    end
    ring_pos_inc = {1'b0, ring_pos} + (CW+1)'(1);
  end

  // ring neighbour: slot 0 follows the last slot in use
  assign active  = MY_POS < cap_i;
  assign last    = (MY_POS + CW'(1)) == cap_i;
  assign nb_data = last ? wrap_data_i : next_data_i;

  // slots from the removed one up to the one before the last entry move up
  assign shift = op_i.sh && active && (ring_pos >= offset_i)
                 && (ring_pos_inc < {1'b0, count_i});

  // next slot contents
  always_comb begin
    data_d = data_q;
    if (op_i.wr && (tail_i == MY_IDX)) begin
      data_d = wdata_i;
    end else if (shift) begin
      data_d = nb_data;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign rd_data_o = (op_i.rd && (rd_idx_i == MY_IDX)) ? data_q : '0;

endmodule

// ===== sv/cfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfq_ctrl
// ring pointers, entry count and capacity register; decodes each
// transaction into strobes for the cell row and a status
// ----------------------------------------------------------------------------
`include "circular_fifo_with_remove_at_slot_defines.svh"

module cfq_ctrl #(
  parameter int unsigned  DEPTH = cfq_pkg::DEPTH_DEF,
  localparam int unsigned IW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cfq_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_fire_i,
  input  logic [1:0]                 in_mode_i,
  input  logic [cfq_pkg::SLOT_W-1:0] in_slot_i,
  output cfq_pkg::cell_op_t          op_o,
  output logic [IW-1:0]              head_o,
  output logic [IW-1:0]              tail_o,
  output logic [IW-1:0]              rd_idx_o,
  output logic [CW-1:0]              offset_o,
  output logic [CW-1:0]              count_o,
  output logic [CW-1:0]              cap_o,
  output logic [CW-1:0]              count_next_o,
  output logic [1:0]                 status_o
);
  import cfq_pkg::*;

  localparam int unsigned SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int unsigned VW = (CW > CFG_W) ? CW : CFG_W;

  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_q, cap_d;

  logic [IW-1:0] head_inc, tail_inc, tail_dec;
  logic [IW-1:0] slot_idx;
  logic [CW-1:0] slot_pos;
  logic [CW-1:0] offset;
  logic          slot_in_ring;
  logic          occupied;
  logic [VW-1:0] cfg_val;
  logic [VW-1:0] cap_sat;
  cell_op_t      op;
  status_e       status;

  // ring pointer steps
  assign head_inc = ((CW'(head_q) + CW'(1)) == cap_q) ? '0 : head_q + IW'(1);
  assign tail_inc = ((CW'(tail_q) + CW'(1)) == cap_q) ? '0 : tail_q + IW'(1);
  assign tail_dec = (tail_q == '0) ? IW'(cap_q - CW'(1)) : tail_q - IW'(1);

  // slot lookup for remove: inside the ring and within the stored entries
  assign slot_in_ring = SW'(in_slot_i) < SW'(cap_q);
  assign slot_idx     = IW'(in_slot_i);
  assign slot_pos     = CW'(slot_idx);

  always_comb begin
    if (slot_pos >= CW'(head_q)) begin
      offset = slot_pos - CW'(head_q);
    end else begin
      offset = slot_pos + cap_q - CW'(head_q);
    end
  end

  assign occupied = slot_in_ring && (offset < count_q);

  // capacity write saturates to one up to the depth
  assign cfg_val = VW'(cfg_wdata_i);
  always_comb begin
    if (cfg_val == '0) begin
      cap_sat = VW'(1);
    end else if (cfg_val > VW'(DEPTH)) begin
      cap_sat = VW'(DEPTH);
    end else begin
      cap_sat = cfg_val;
    end
  end

  // transaction decode and next pointer state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    cap_d   = cap_q;
    op      = '0;
    status  = STAT_OK;
    if (cfg_we_i) begin
      cap_d   = CW'(cap_sat);
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (in_fire_i) begin
      unique case (in_mode_i)
        MODE_ENQ: begin
          if (count_q >= cap_q) begin
            status = STAT_FULL;
          end else begin
            op.wr   = 1'b1;
            tail_d  = tail_inc;
            count_d = count_q + CW'(1);
          end
        end
        MODE_DEQ: begin
          if (count_q == '0) begin
            status = STAT_EMPTY;
          end else begin
            op.rd   = 1'b1;
            head_d  = head_inc;
            count_d = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              head_d = '0;
              tail_d = '0;
            end
          end
        end
        MODE_REM: begin
          if (!occupied) begin
            status = STAT_NO_SLOT;
          end else begin
            op.rd   = 1'b1;
            op.sh   = 1'b1;
            tail_d  = tail_dec;
            count_d = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              head_d = '0;
              tail_d = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pointer, count and capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cap_q   <= CW'(DEPTH);
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  assign op_o         = op;
  assign head_o       = head_q;
  assign tail_o       = tail_q;
  assign rd_idx_o     = (in_mode_i == MODE_DEQ) ? head_q : slot_idx;
  assign offset_o     = offset;
  assign count_o      = count_q;
  assign cap_o        = cap_q;
  assign count_next_o = count_d;
  assign status_o     = status;

  // checks
  `CFQ_ASSERT(a_count_in_ring, clk_i, rst_ni, count_q <= cap_q, "entry count above capacity")
  `CFQ_ASSERT_IMPL(a_empty_at_zero, clk_i, rst_ni, count_q == '0, (head_q == '0) && (tail_q == '0), "empty queue with pointers off slot zero")
  `CFQ_ASSERT(a_error_holds, clk_i, rst_ni, (in_fire_i && (status_o != STAT_OK)) |=> ($stable(count_q) && $stable(head_q) && $stable(tail_q)), "failed transaction changed the queue")

endmodule

// ===== sv/circular_fifo_with_remove_at_slot.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_remove_at_slot
// circular fifo over a row of slot cells with enqueue, dequeue and
// remove-at-slot; removal closes the gap by shifting cells toward the head
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid_i/in_stall_o  in_data_i   (cfq_in_t)
//  out       output     out_valid_o/out_stall_i out_data_o (cfq_out_t)
//  cfg       input      apb psel/penable/pready paddr/pwdata/prdata
//
//  one transaction per cycle for every operation while in_stall_o is low;
//  the result sits in the output register from the cycle after acceptance
//  remove-at-slot compacts in that same cycle: every cell behind the removed
//  slot loads its ring neighbour at once
//  reset clears pointers and count and sets the capacity to the full depth;
//  slot contents are not cleared
//  input stalls only while a result waits and the output side stalls
// ----------------------------------------------------------------------------
`include "circular_fifo_with_remove_at_slot_defines.svh"

module circular_fifo_with_remove_at_slot #(
  parameter int unsigned DEPTH = cfq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cfq_pkg::cfq_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cfq_pkg::cfq_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfq_pkg::PADDR_W-1:0] paddr,
  input  logic [cfq_pkg::PDATA_W-1:0] pwdata,
  output logic [cfq_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import cfq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              in_fire;
  logic              cfg_we;
  cell_op_t          op;
  logic [IW-1:0]     head, tail, rd_idx;
  logic [CW-1:0]     offset, count, cap, count_next;
  logic [1:0]        status;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];
  logic [DATA_W-1:0] removed;
  logic              out_valid_q, out_valid_d;
  cfq_out_t          out_data_q, out_data_d;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_CAPACITY);
  assign prdata = (paddr == REG_CAPACITY) ? PDATA_W'(cap) : '0;

  // pointer control
  cfq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[CFG_W-1:0]),
    .in_fire_i    (in_fire),
    .in_mode_i    (in_data_i.mode),
    .in_slot_i    (in_data_i.slot),
    .op_o         (op),
    .head_o       (head),
    .tail_o       (tail),
    .rd_idx_o     (rd_idx),
    .offset_o     (offset),
    .count_o      (count),
    .cap_o        (cap),
    .count_next_o (count_next),
    .status_o     (status)
  );

  // row of slot cells, each fed by its upper neighbour
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned NXT = (g == DEPTH - 1) ? 0 : g + 1;
    cfq_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .cap_i       (cap),
      .head_i      (head),
      .tail_i      (tail),
      .rd_idx_i    (rd_idx),
      .offset_i    (offset),
      .count_i     (count),
      .wdata_i     (in_data_i.value),
      .next_data_i (cell_data[NXT]),
      .wrap_data_i (cell_data[0]),
      .data_o      (cell_data[g]),
      .rd_data_o   (cell_rd[g])
    );
  end

  // read bus: only the addressed cell drives a non-zero word
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | cell_rd[i];
    end
  end

  // result of the accepted transaction
  always_comb begin
    out_data_d.removed_value = removed;
    out_data_d.status        = status;
    out_data_d.entry_count   = COUNT_W'(count_next);
    out_data_d.is_empty      = (count_next == '0);
    out_data_d.is_full       = (count_next == cap);
  end

  assign out_valid_d = in_fire || (out_valid_q && out_stall_i);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `CFQ_ASSERT(a_result_follows, clk_i, rst_ni, in_fire |=> out_valid_o, "accepted transaction gave no result")
  `CFQ_ASSERT_IMPL(a_error_no_value, clk_i, rst_ni, out_valid_o && (out_data_o.status != STAT_OK), out_data_o.removed_value == '0, "failed transaction returned a value")
  `CFQ_ASSERT_IMPL(a_full_not_empty, clk_i, rst_ni, out_valid_o && out_data_o.is_full, !out_data_o.is_empty, "result flagged both full and empty")

endmodule

// ===== tb/sv/circular_fifo_with_remove_at_slot_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_remove_at_slot_test
// self-checking bench for the circular fifo with remove-at-slot: a queue-fed
// driver offers enqueue, dequeue, remove and unused-mode transactions with
// random gaps, a monitor predicts each result from a shadow ring and checks
// every output field, and the capacity register is swept between phases
// ----------------------------------------------------------------------------
module circular_fifo_with_remove_at_slot_test;
  import cfq_pkg::*;

  localparam int unsigned RING_SLOTS = DEPTH_DEF;
  localparam logic [1:0]  MODE_NOP   = 2'd3;  // unused operation code
  localparam int          QUIET_MAX  = 4000;  // cycles with no transaction
  localparam int          HOLD_LEN   = 60;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  cfq_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  cfq_out_t            out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = REG_CAPACITY;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // shadow copy of the ring
  logic [DATA_W-1:0]   shadow_slots [RING_SLOTS];
  int                  shadow_head;
  int                  shadow_tail;
  int                  shadow_fill;
  int                  shadow_cap;

  cfq_in_t             send_items [$];
  cfq_out_t            expected_results [$];
  logic                in_taken     = 1'b0;
  logic                steady       = 1'b0;
  logic                hold_done    = 1'b0;
  int                  hold_left    = 0;
  int                  quiet_cycles = 0;
  int                  items_in     = 0;
  int                  results_seen = 0;
  int                  mismatches   = 0;
  int                  status_hits [4] = '{0, 0, 0, 0};
  int                  caps_used    = 1;

  circular_fifo_with_remove_at_slot #(
    .DEPTH(RING_SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // empty the shadow ring, pointers back to slot 0
  function automatic void clear_shadow();
    shadow_head = 0;
    shadow_tail = 0;
    shadow_fill = 0;
  endfunction

  // apply one operation to the shadow ring and return the expected result
  function automatic cfq_out_t fifo_apply_op(cfq_in_t op);
    cfq_out_t          res;
    logic [DATA_W-1:0] taken;
    logic [1:0]        st;
    int                off;
    int                dst;
    logic              occupied;
    taken    = '0;
    st       = STAT_OK;
    occupied = 1'b0;
    off      = 0;
    case (op.mode)
      MODE_ENQ: begin
        if (shadow_fill >= shadow_cap) begin
          st = STAT_FULL;
        end else begin
          shadow_slots[shadow_tail] = op.value;
          shadow_tail = (shadow_tail + 1) % shadow_cap;
          shadow_fill++;
        end
      end
      MODE_DEQ: begin
        if (shadow_fill == 0) begin
          st = STAT_EMPTY;
        end else begin
          taken = shadow_slots[shadow_head];
          shadow_head = (shadow_head + 1) % shadow_cap;
          shadow_fill--;
          if (shadow_fill == 0) clear_shadow();
        end
      end
      MODE_REM: begin
        if (int'(op.slot) < shadow_cap) begin
          off      = (int'(op.slot) + shadow_cap - shadow_head) % shadow_cap;
          occupied = (off < shadow_fill);
        end
        if (!occupied) begin
          st = STAT_NO_SLOT;
        end else begin
          taken = shadow_slots[op.slot];
          // later entries close the gap toward the head
          for (int k = off; k + 1 < shadow_fill; k++) begin
            dst = (shadow_head + k) % shadow_cap;
            shadow_slots[dst] = shadow_slots[(dst + 1) % shadow_cap];
          end
          shadow_tail = (shadow_tail + shadow_cap - 1) % shadow_cap;
          shadow_fill--;
          if (shadow_fill == 0) clear_shadow();
        end
      end
      default: ;
    endcase
    res.removed_value = taken;
    res.status        = st;
    res.entry_count   = shadow_fill[COUNT_W-1:0];
    res.is_empty      = (shadow_fill == 0);
    res.is_full       = (shadow_fill == shadow_cap);
    return res;
  endfunction

  // input driver: one transaction held until taken, random gaps otherwise
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_items.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
        in_data_i  <= send_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure, with one long hold while the sender keeps going
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && results_seen >= 100 && send_items.size() != 0) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 26);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    cfq_out_t want;
    if (!rst_ni) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(fifo_apply_op(in_data_i));
        items_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, out_data_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          status_hits[want.status]++;
          if (out_data_o.removed_value !== want.removed_value) begin
            $display("%0t removed_value: expected %h, got %h", $time,
                     want.removed_value, out_data_o.removed_value);
            mismatches++;
          end
          if (out_data_o.status !== want.status) begin
            $display("%0t status: expected %0d, got %0d", $time,
                     want.status, out_data_o.status);
            mismatches++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $display("%0t entry_count: expected %0d, got %0d", $time,
                     want.entry_count, out_data_o.entry_count);
            mismatches++;
          end
          if (out_data_o.is_empty !== want.is_empty) begin
            $display("%0t is_empty: expected %b, got %b", $time,
                     want.is_empty, out_data_o.is_empty);
            mismatches++;
          end
          if (out_data_o.is_full !== want.is_full) begin
            $display("%0t is_full: expected %b, got %b", $time,
                     want.is_full, out_data_o.is_full);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog on a stuck handshake
  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk_i);
    $display("%0t no transaction for %0d cycles", $time, QUIET_MAX);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic queue_op(logic [1:0] mode, logic [DATA_W-1:0] value,
                          logic [SLOT_W-1:0] slot);
    cfq_in_t op;
    op.mode  = mode;
    op.value = value;
    op.slot  = slot;
    send_items.push_back(op);
  endtask

  // random transactions in bursts that lean toward filling, stay balanced or lean toward draining
  task automatic queue_random(int n);
    int                enq_pct;
    int                r;
    logic [DATA_W-1:0] v;
    logic [SLOT_W-1:0] s;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 15;
        endcase
      end
      v = $urandom();
      if ($urandom_range(9) == 0) v = $urandom_range(1) ? '1 : '0;
      s = ($urandom_range(4) == 0) ? SLOT_W'($urandom_range(RING_SLOTS - 1))
                                   : SLOT_W'($urandom_range(shadow_cap - 1));
      r = $urandom_range(99);
      if (r < 3)                       queue_op(MODE_NOP, v, s);
      else if (r < 3 + enq_pct)        queue_op(MODE_ENQ, v, s);
      else if ($urandom_range(9) < 6)  queue_op(MODE_DEQ, v, s);
      else                             queue_op(MODE_REM, v, s);
    end
  endtask

  // wait until every queued transaction has gone through and been checked
  task automatic wait_drained();
    @(posedge clk_i);
    #1;
    while (send_items.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  // apb write of the capacity register, queue idle
  task automatic write_capacity(logic [PDATA_W-1:0] v);
    int c;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_CAPACITY;
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // saturate to 1..ring size, the queue is emptied
    c = int'(v[CFG_W-1:0]);
    if (c < 1) c = 1;
    if (c > RING_SLOTS) c = RING_SLOTS;
    shadow_cap = c;
    clear_shadow();
    caps_used++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int phase_caps [7];
    int phase_len [7];
    phase_caps = '{16, 1, 0, 31, 5, 3, 9};
    phase_len  = '{120, 60, 40, 100, 100, 80, 100};
    for (int i = 0; i < RING_SLOTS; i++) shadow_slots[i] = '0;
    shadow_cap = RING_SLOTS;
    clear_shadow();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity: empty errors, unused mode, data extremes, last-entry removal
    queue_op(MODE_DEQ, 32'h0, 4'd0);
    queue_op(MODE_REM, 32'h0, 4'd0);
    queue_op(MODE_NOP, 32'hFFFF_FFFF, 4'd15);
    queue_op(MODE_ENQ, 32'h0000_0000, 4'd0);
    queue_op(MODE_ENQ, 32'hFFFF_FFFF, 4'd15);
    queue_op(MODE_REM, 32'h0, 4'd15);
    queue_op(MODE_DEQ, 32'h0, 4'd0);
    queue_op(MODE_REM, 32'h0, 4'd1);
    queue_op(MODE_ENQ, 32'h5A5A_5A5A, 4'd0);
    queue_op(MODE_DEQ, 32'h0, 4'd0);
    wait_drained();

    // two slots: full, slot outside the ring, wrap of the tail, removal across the wrap
    write_capacity(32'd2);
    queue_op(MODE_ENQ, 32'h0000_0001, 4'd0);
    queue_op(MODE_ENQ, 32'h0000_0002, 4'd0);
    queue_op(MODE_ENQ, 32'h0000_0003, 4'd0);
    queue_op(MODE_REM, 32'h0, 4'd2);
    queue_op(MODE_DEQ, 32'h0, 4'd0);
    queue_op(MODE_ENQ, 32'hA5A5_A5A5, 4'd0);
    queue_op(MODE_REM, 32'h0, 4'd0);
    queue_op(MODE_REM, 32'h0, 4'd1);
    queue_op(MODE_DEQ, 32'h0, 4'd0);
    wait_drained();

    // random phases over a sweep of capacities, one without gaps
    for (int p = 0; p < 7; p++) begin
      write_capacity(phase_caps[p]);
      steady = (p == 3);
      queue_random(phase_len[p]);
      wait_drained();
      steady = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    $display("summary: %0d transactions in, %0d results, %0d capacity settings",
             items_in, results_seen, caps_used);
    $display("summary: status ok %0d, full %0d, empty %0d, no slot %0d",
             status_hits[STAT_OK], status_hits[STAT_FULL],
             status_hits[STAT_EMPTY], status_hits[STAT_NO_SLOT]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
